@@ rtl/core/wsrm_pkg.sv @@
// Shared constants, request types and helpers for the wildcard/star matcher.
`default_nettype none

package wsrm_pkg;

  // Pattern store size and the row sequencer that walks it
  localparam int MAX_PATTERN = 32;
  localparam int LANES       = 8;
  localparam int NUM_CHUNKS  = (MAX_PATTERN + LANES - 1) / LANES;
  localparam int PAD         = NUM_CHUNKS * LANES;
  localparam int ROW_IDX_W   = $clog2(PAD);
  localparam int CNT_W       = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 5;
  localparam int SYM_W    = 8;
  localparam int LEN_W    = 6;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_BYTE  = 2'd2;

  // Special pattern bytes
  localparam logic [SYM_W-1:0] SYM_STAR = 8'd42;
  localparam logic [SYM_W-1:0] SYM_DOT  = 8'd46;

  // Request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_START,
    KIND_BYTE
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [INDEX_W-1:0]  index;
    logic [SYM_W-1:0]    symbol;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } slot_t;

  // A pattern byte accepts a subject byte if equal or a dot
  function automatic logic accepts(logic [SYM_W-1:0] pat, logic [SYM_W-1:0] ch);
    return (pat == ch) || (pat == SYM_DOT);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/wsrm_if.sv @@
// Valid/ready channel interfaces for matcher requests and match results.
`default_nettype none

interface wsrm_in_if;
  logic                          valid;
  logic                          ready;
  logic [wsrm_pkg::OPCODE_W-1:0] opcode;
  logic [wsrm_pkg::INDEX_W-1:0]  pattern_index;
  logic [wsrm_pkg::SYM_W-1:0]    symbol;

  modport source (output valid, opcode, pattern_index, symbol, input ready);
  modport sink   (input valid, opcode, pattern_index, symbol, output ready);
endinterface

interface wsrm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wsrm_front.sv @@
// Front end: takes requests off the input channel and classifies them.
`default_nettype none

module wsrm_front (
  wsrm_in_if.sink          in_i,
  input  logic             full_i,
  output wsrm_pkg::slot_t  push_o
);

  // Accept whenever the queue has room
  assign in_i.ready = !full_i;

  // Decode opcode; drop the unused code
  always_comb begin
    push_o.valid      = 1'b0;
    push_o.req.kind   = wsrm_pkg::KIND_WRITE;
    push_o.req.index  = in_i.pattern_index;
    push_o.req.symbol = in_i.symbol;
    case (in_i.opcode)
      wsrm_pkg::OP_WRITE: begin
        push_o.valid    = in_i.valid && !full_i;
        push_o.req.kind = wsrm_pkg::KIND_WRITE;
      end
      wsrm_pkg::OP_START: begin
        push_o.valid    = in_i.valid && !full_i;
        push_o.req.kind = wsrm_pkg::KIND_START;
      end
      wsrm_pkg::OP_BYTE: begin
        push_o.valid    = in_i.valid && !full_i;
        push_o.req.kind = wsrm_pkg::KIND_BYTE;
      end
      default: begin
        push_o.valid = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/wsrm_queue.sv @@
// Short request FIFO that decouples the front end from the back end.
`default_nettype none

module wsrm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wsrm_pkg::slot_t  push_i,
  output logic             full_o,
  output wsrm_pkg::slot_t  head_o,
  input  logic             pop_i
);

  wsrm_pkg::req_t                  mem_q [wsrm_pkg::QDEPTH];
  logic [wsrm_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [wsrm_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [wsrm_pkg::QCNT_W-1:0]     count_q, count_d;
  logic                            do_push;
  logic                            do_pop;

  assign full_o       = (count_q == wsrm_pkg::QCNT_W'(wsrm_pkg::QDEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.req   = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // Advance pointers with wrap, track fill
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      if (wr_ptr_q == wsrm_pkg::QPTR_W'(wsrm_pkg::QDEPTH - 1)) begin
        wr_ptr_d = '0;
      end else begin
        wr_ptr_d = wr_ptr_q + 1'b1;
      end
    end
    if (do_pop) begin
      if (rd_ptr_q == wsrm_pkg::QPTR_W'(wsrm_pkg::QDEPTH - 1)) begin
        rd_ptr_d = '0;
      end else begin
        rd_ptr_d = rd_ptr_q + 1'b1;
      end
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.req;
    end
  end

  // Fill never exceeds the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= wsrm_pkg::QCNT_W'(wsrm_pkg::QDEPTH))
    else $error("queue fill above depth");

  // A push into a full queue leaves the fill unchanged unless a pop frees a slot
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o)
    else $error("full queue lost an entry without a pop");

endmodule

`default_nettype wire

@@ rtl/core/wsrm_back.sv @@
// Back end: pattern store, match row sequencer and result register.
`default_nettype none

module wsrm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wsrm_pkg::slot_t               head_i,
  output logic                          pop_o,
  input  logic [wsrm_pkg::LEN_W-1:0]    pattern_length_i,
  wsrm_out_if.source                    out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int PAD   = wsrm_pkg::PAD;
  localparam int LANES = wsrm_pkg::LANES;
  localparam logic [wsrm_pkg::CNT_W-1:0] LAST_CHUNK =
    wsrm_pkg::CNT_W'(wsrm_pkg::NUM_CHUNKS - 1);

  logic [1:0]                     state_q, state_d;
  logic [wsrm_pkg::CNT_W-1:0]     chunk_q, chunk_d;
  logic                           start_mode_q, start_mode_d;
  logic [wsrm_pkg::SYM_W-1:0]     ch_q, ch_d;
  logic                           row0_q, row0_d;
  logic [PAD-1:0]                 row_q, row_d;
  logic                           old_q, old_d;
  logic                           nm1_q, nm1_d;
  logic                           nm2_q, nm2_d;
  logic [wsrm_pkg::SYM_W-1:0]     pprev_q, pprev_d;
  logic [wsrm_pkg::SYM_W-1:0]     pat_q [PAD];
  logic [wsrm_pkg::SYM_W-1:0]     pat_rot [PAD];
  logic                           pat_wr_en;
  logic                           pat_rot_en;
  logic [LANES-1:0]               lane_new;
  logic [PAD-1:0]                 row_rot;
  logic                           out_valid_q, out_valid_d;
  logic                           out_matched_q, out_matched_d;
  logic                           out_load;
  logic [wsrm_pkg::LEN_W-1:0]     len_eff;
  logic [wsrm_pkg::ROW_IDX_W-1:0] len_sel;
  logic                           match_sel;

  // Compute one window of LANES row entries from the front of the rotating row
  always_comb begin
    logic [wsrm_pkg::SYM_W-1:0] p;
    logic [wsrm_pkg::SYM_W-1:0] pp;
    logic                       new2;
    logic                       old1;
    logic                       old0;
    logic                       star;
    lane_new = '0;
    for (int i = 0; i < LANES; i++) begin
      p = pat_q[i];
      if (i == 0) begin
        pp   = pprev_q;
        old1 = old_q;
        new2 = nm2_q;
      end else if (i == 1) begin
        pp   = pat_q[i-1];
        old1 = row_q[i-1];
        new2 = nm1_q;
      end else begin
        pp   = pat_q[i-1];
        old1 = row_q[i-1];
        new2 = lane_new[i-2];
      end
      old0 = row_q[i];
      // a star in pattern position zero never matches
      star = (p == wsrm_pkg::SYM_STAR) && !((i == 0) && (chunk_q == '0));
      if (start_mode_q) begin
        lane_new[i] = star && new2;
      end else if (wsrm_pkg::accepts(p, ch_q)) begin
        lane_new[i] = old1;
      end else if (star) begin
        lane_new[i] = new2 || (wsrm_pkg::accepts(pp, ch_q) && old0);
      end else begin
        lane_new[i] = 1'b0;
      end
    end
  end

  // Rotate row and pattern by one window; new entries go to the back
  always_comb begin
    for (int m = 0; m < PAD; m++) begin
      if (m < PAD - LANES) begin
        row_rot[m] = row_q[m + LANES];
      end else begin
        row_rot[m] = lane_new[m - (PAD - LANES)];
      end
      if (m + LANES < PAD) begin
        pat_rot[m] = pat_q[m + LANES];
      end else begin
        pat_rot[m] = pat_q[m + LANES - PAD];
      end
    end
  end

  // Pick row entry at the clipped pattern length
  always_comb begin
    if (int'(pattern_length_i) > wsrm_pkg::MAX_PATTERN) begin
      len_eff = wsrm_pkg::LEN_W'(wsrm_pkg::MAX_PATTERN);
    end else begin
      len_eff = pattern_length_i;
    end
    len_sel = wsrm_pkg::ROW_IDX_W'(len_eff - 1'b1);
    if (len_eff == '0) begin
      match_sel = row0_q;
    end else begin
      match_sel = row_q[len_sel];
    end
  end

  // Sequencer: dispatch, walk the row window by window, hand off the result
  always_comb begin
    state_d      = state_q;
    chunk_d      = chunk_q;
    start_mode_d = start_mode_q;
    ch_d         = ch_q;
    row0_d       = row0_q;
    row_d        = row_q;
    old_d        = old_q;
    nm1_d        = nm1_q;
    nm2_d        = nm2_q;
    pprev_d      = pprev_q;
    pop_o        = 1'b0;
    pat_wr_en    = 1'b0;
    pat_rot_en   = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          case (head_i.req.kind)
            wsrm_pkg::KIND_WRITE: begin
              pat_wr_en = int'(head_i.req.index) < wsrm_pkg::MAX_PATTERN;
            end
            wsrm_pkg::KIND_START: begin
              start_mode_d = 1'b1;
              row0_d       = 1'b1;
              old_d        = row0_q;
              nm1_d        = 1'b1;
              chunk_d      = '0;
              state_d      = ST_RUN;
            end
            wsrm_pkg::KIND_BYTE: begin
              start_mode_d = 1'b0;
              ch_d         = head_i.req.symbol;
              row0_d       = 1'b0;
              old_d        = row0_q;
              nm1_d        = 1'b0;
              chunk_d      = '0;
              state_d      = ST_RUN;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_RUN: begin
        row_d      = row_rot;
        pat_rot_en = 1'b1;
        old_d      = row_q[LANES-1];
        nm1_d      = lane_new[LANES-1];
        nm2_d      = lane_new[LANES-2];
        pprev_d    = pat_q[LANES-1];
        if (chunk_q == LAST_CHUNK) begin
          state_d = ST_DONE;
        end else begin
          chunk_d = chunk_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register; hold while the sink stalls
  always_comb begin
    out_matched_d = out_matched_q;
    if (out_load) begin
      out_valid_d   = 1'b1;
      out_matched_d = match_sel;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.matched = out_matched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chunk_q     <= '0;
      row0_q      <= 1'b0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chunk_q     <= chunk_d;
      row0_q      <= row0_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_mode_q  <= start_mode_d;
    ch_q          <= ch_d;
    old_q         <= old_d;
    nm1_q         <= nm1_d;
    nm2_q         <= nm2_d;
    pprev_q       <= pprev_d;
    out_matched_q <= out_matched_d;
  end

  // Pattern store: write one symbol at rest, rotate while walking
  always_ff @(posedge clk_i) begin
    if (pat_wr_en) begin
      for (int m = 0; m < PAD; m++) begin
        if (m == int'(head_i.req.index)) begin
          pat_q[m] <= head_i.req.symbol;
        end
      end
    end else if (pat_rot_en) begin
      pat_q <= pat_rot;
    end
  end

  // A result only comes out of the hand-off state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == ST_DONE))
    else $error("result raised outside hand-off");

  // The last window always leads to the hand-off state
  a_last_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && chunk_q == LAST_CHUNK) |=> (state_q == ST_DONE))
    else $error("row walk did not finish after the last window");

  // No request is taken while a row walk or hand-off is pending
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN || state_q == ST_DONE) |-> !pop_o)
    else $error("request popped while busy");

endmodule

`default_nettype wire

@@ rtl/core/wildcard_star_regex_matcher_core.sv @@
// Top level of the streaming literal/dot/star pattern matcher.
//
// Requests arrive on in_i: opcode 0 writes one pattern symbol (no result),
// opcode 1 starts a subject and opcode 2 feeds one subject byte; each of the
// latter two returns one result on out_o telling whether the subject so far
// matches the first pattern_length symbols ('.' any byte, '*' zero or more of
// the symbol before it, '*' in position zero never matches). Opcode 3 is
// taken and dropped. A two-entry request queue lets input be accepted while
// the back end works. A pattern write is done at dispatch; for a start or a
// subject byte the back end dispatches, the row sequencer walks the match row
// one eight-position window at a time, and then the result register is loaded.
// The user must write pattern_length only while the block is idle; the block
// does not enforce it. Values above the pattern capacity clip to it.
`default_nettype none

module wildcard_star_regex_matcher_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pattern_length_we_i,
  input  logic [wsrm_pkg::LEN_W-1:0]    pattern_length_i,
  wsrm_in_if.sink                       in_i,
  wsrm_out_if.source                    out_o
);

  logic [wsrm_pkg::LEN_W-1:0] pattern_length_q;
  wsrm_pkg::slot_t            push;
  wsrm_pkg::slot_t            head;
  logic                       full;
  logic                       pop;

  // Hold the pattern length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= '0;
    end else if (pattern_length_we_i) begin
      pattern_length_q <= pattern_length_i;
    end
  end

  wsrm_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  wsrm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  wsrm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .pop_o            (pop),
    .pattern_length_i (pattern_length_q),
    .out_o            (out_o)
  );

endmodule

`default_nettype wire

@@ dv/tb_wildcard_star_regex_matcher_core.sv @@
// Self-checking testbench for the streaming literal/dot/star pattern matcher core.
module tb_wildcard_star_regex_matcher_core;

  localparam logic [wsrm_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int ROW_W     = wsrm_pkg::MAX_PATTERN + 1;
  localparam int N_PHASES  = 8;
  localparam int PHASE_REQ = 210;
  localparam int HOLD_LEN  = 400;

  typedef struct packed {
    logic [wsrm_pkg::OPCODE_W-1:0] opcode;
    logic [wsrm_pkg::INDEX_W-1:0]  index;
    logic [wsrm_pkg::SYM_W-1:0]    symbol;
  } request_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       len_we;
  logic [wsrm_pkg::LEN_W-1:0] len_val;

  wsrm_in_if  req_if ();
  wsrm_out_if res_if ();

  wildcard_star_regex_matcher_core DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .pattern_length_we_i (len_we),
    .pattern_length_i    (len_val),
    .in_i                (req_if),
    .out_o               (res_if)
  );

  // Row predictor state
  logic [wsrm_pkg::SYM_W-1:0]       pat_mem [wsrm_pkg::MAX_PATTERN];
  logic [ROW_W-1:0]                 prefix_row;
  logic [wsrm_pkg::LEN_W-1:0]       cur_len;
  logic [wsrm_pkg::MAX_PATTERN-1:0] written;
  logic                             match_q [$];

  // Stimulus state
  request_t   pending_q [$];
  request_t   cur_req;
  idle_mode_e idle_mode;
  int         hold_left;
  int         err_cnt;
  int         phase_reqs;
  logic       exp_match;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic logic byte_fits(logic [wsrm_pkg::SYM_W-1:0] pat,
                                     logic [wsrm_pkg::SYM_W-1:0] ch);
    return (pat == ch) || (pat == wsrm_pkg::SYM_DOT);
  endfunction

  // Apply one accepted request to the predicted row and queue the expected answer
  task automatic predict_match(input request_t r);
    logic [ROW_W-1:0]           nxt;
    logic [wsrm_pkg::SYM_W-1:0] p;
    logic                       v;
    int                         act;
    nxt = '0;
    case (r.opcode)
      wsrm_pkg::OP_WRITE: begin
        pat_mem[r.index] = r.symbol;
      end
      wsrm_pkg::OP_START: begin
        nxt[0] = 1'b1;
        for (int j = 1; j <= wsrm_pkg::MAX_PATTERN; j++) begin
          if (pat_mem[j-1] == wsrm_pkg::SYM_STAR && j >= 2) nxt[j] = nxt[j-2];
        end
        prefix_row = nxt;
      end
      wsrm_pkg::OP_BYTE: begin
        for (int j = 1; j <= wsrm_pkg::MAX_PATTERN; j++) begin
          p = pat_mem[j-1];
          v = 1'b0;
          if (byte_fits(p, r.symbol)) begin
            v = prefix_row[j-1];
          end else if (p == wsrm_pkg::SYM_STAR && j >= 2) begin
            v = nxt[j-2];
            if (byte_fits(pat_mem[j-2], r.symbol)) v = v | prefix_row[j];
          end
          nxt[j] = v;
        end
        prefix_row = nxt;
      end
      default: ;
    endcase
    if (r.opcode == wsrm_pkg::OP_START || r.opcode == wsrm_pkg::OP_BYTE) begin
      act = (cur_len > wsrm_pkg::MAX_PATTERN) ? wsrm_pkg::MAX_PATTERN : int'(cur_len);
      match_q.push_back(prefix_row[act]);
    end
  endtask

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 50;
      IDLE_BOTH: return $urandom_range(99) < 26;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 50;
      IDLE_BOTH: return $urandom_range(99) < 26;
      default:   return 1'b0;
    endcase
  endfunction

  // Drive requests from the pending queue, predicting each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) predict_match(cur_req);
      if (!req_if.valid || req_if.ready) begin
        if (pending_q.size() > 0 && !sender_idles()) begin
          cur_req = pending_q.pop_front();
          req_if.valid         <= 1'b1;
          req_if.opcode        <= cur_req.opcode;
          req_if.pattern_index <= cur_req.index;
          req_if.symbol        <= cur_req.symbol;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Count down the long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  task automatic note_mismatch(input string what, input logic expv, input logic actv);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%0t: result mismatch (%s): expected matched=%0b, actual matched=%0b",
               $realtime, what, expv, actv);
    end
  endtask

  // Check each accepted result against the oldest expectation and drive ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (match_q.size() == 0) begin
          note_mismatch("no result expected", 1'bx, res_if.matched);
        end else begin
          exp_match = match_q.pop_front();
          if (exp_match !== res_if.matched) begin
            note_mismatch("wrong value", exp_match, res_if.matched);
          end
        end
      end
      res_if.ready <= (hold_left == 0) && !receiver_stalls();
    end
  end

  function automatic logic [wsrm_pkg::INDEX_W-1:0] rand_index();
    return wsrm_pkg::INDEX_W'($urandom_range(31));
  endfunction

  function automatic logic [wsrm_pkg::SYM_W-1:0] rand_byte();
    return wsrm_pkg::SYM_W'($urandom_range(255));
  endfunction

  task automatic push_req(input logic [wsrm_pkg::OPCODE_W-1:0] op,
                          input logic [wsrm_pkg::INDEX_W-1:0]  idx,
                          input logic [wsrm_pkg::SYM_W-1:0]    sym);
    request_t r;
    r.opcode = op;
    r.index  = idx;
    r.symbol = sym;
    pending_q.push_back(r);
    phase_reqs++;
    if (op == wsrm_pkg::OP_WRITE) written[idx] = 1'b1;
  endtask

  // Wait until every request is taken and every result is back, then let writes drain
  task automatic wait_idle();
    while (pending_q.size() > 0 || req_if.valid || match_q.size() > 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_length(input int v);
    @(posedge clk_i);
    len_we  <= 1'b1;
    len_val <= v[wsrm_pkg::LEN_W-1:0];
    @(posedge clk_i);
    len_we  <= 1'b0;
    cur_len = v[wsrm_pkg::LEN_W-1:0];
    @(negedge clk_i);
  endtask

  function automatic logic [wsrm_pkg::SYM_W-1:0] subject_char();
    if ($urandom_range(99) < 80) return wsrm_pkg::SYM_W'(8'h61 + $urandom_range(2));
    return rand_byte();
  endfunction

  function automatic logic [wsrm_pkg::SYM_W-1:0] pattern_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return wsrm_pkg::SYM_W'(8'h61 + $urandom_range(2));
    if (roll < 65) return wsrm_pkg::SYM_DOT;
    if (roll < 90) return wsrm_pkg::SYM_STAR;
    return rand_byte();
  endfunction

  function automatic bit pattern_in_place(input int n);
    for (int i = 0; i < n; i++) begin
      if (!written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Mostly well-formed pattern/subject sequences, with some noise mixed in
  task automatic fill_random_phase(input int len, input int n_reqs);
    logic [wsrm_pkg::SYM_W-1:0] pat [wsrm_pkg::MAX_PATTERN];
    logic [wsrm_pkg::SYM_W-1:0] subj [$];
    logic [wsrm_pkg::SYM_W-1:0] p;
    int                         act;
    int                         roll;
    int                         reps;
    int                         pos;
    bit                         starred;
    act = (len > wsrm_pkg::MAX_PATTERN) ? wsrm_pkg::MAX_PATTERN : len;
    phase_reqs = 0;
    // continue the running subject under the new length
    if (pattern_in_place(act)) begin
      repeat (3) push_req(wsrm_pkg::OP_BYTE, rand_index(), subject_char());
    end
    while (phase_reqs < n_reqs) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        push_req(OP_UNUSED, rand_index(), rand_byte());
      end else if (roll < 10) begin
        push_req(wsrm_pkg::OP_WRITE, rand_index(), rand_byte());
      end else if (roll < 13 && pattern_in_place(act)) begin
        // stray byte only once the active pattern is fully written
        push_req(wsrm_pkg::OP_BYTE, rand_index(), rand_byte());
      end else begin
        for (int k = 0; k < act; k++) begin
          pat[k] = pattern_char();
          push_req(wsrm_pkg::OP_WRITE, k[wsrm_pkg::INDEX_W-1:0], pat[k]);
        end
        push_req(wsrm_pkg::OP_START, rand_index(), rand_byte());
        // build a subject that the pattern accepts, then maybe break it
        subj.delete();
        for (int k = 0; k < act; k++) begin
          p = pat[k];
          starred = (k + 1 < act) && (pat[k+1] == wsrm_pkg::SYM_STAR);
          if (p == wsrm_pkg::SYM_STAR && !starred) continue;
          reps = starred ? $urandom_range(3) : 1;
          repeat (reps) subj.push_back((p == wsrm_pkg::SYM_DOT) ? subject_char() : p);
        end
        roll = $urandom_range(99);
        if (roll < 30 && subj.size() > 0) begin
          pos = $urandom_range(subj.size() - 1);
          subj[pos] = subject_char();
        end else if (roll < 40) begin
          subj.push_back(subject_char());
        end else if (roll < 45 && subj.size() > 0) begin
          pos = $urandom_range(subj.size() - 1);
          subj.delete(pos);
        end
        foreach (subj[i]) push_req(wsrm_pkg::OP_BYTE, rand_index(), subj[i]);
      end
    end
  endtask

  function automatic int phase_length(input int ph);
    case (ph)
      0:       return 5;
      1:       return 32;
      2:       return 1;
      3:       return 63;
      4:       return 12;
      5:       return 3;
      6:       return 40;
      default: return 8;
    endcase
  endfunction

  initial begin
    rst_ni               = 1'b0;
    len_we               = 1'b0;
    len_val              = '0;
    req_if.valid         = 1'b0;
    req_if.opcode        = '0;
    req_if.pattern_index = '0;
    req_if.symbol        = '0;
    res_if.ready         = 1'b0;
    foreach (pat_mem[i]) pat_mem[i] = '0;
    prefix_row = '0;
    cur_len    = '0;
    written    = '0;
    idle_mode  = IDLE_NONE;
    hold_left  = 0;
    err_cnt    = 0;
    phase_reqs = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty pattern: byte before any start, dropped opcode, field extremes
    push_req(wsrm_pkg::OP_BYTE, 5'd0, 8'hFF);
    push_req(OP_UNUSED, 5'd31, 8'hFF);
    push_req(wsrm_pkg::OP_START, 5'd0, 8'h00);
    push_req(wsrm_pkg::OP_BYTE, 5'd0, 8'h00);
    push_req(wsrm_pkg::OP_WRITE, 5'd31, 8'hFF);
    push_req(wsrm_pkg::OP_WRITE, 5'd0, 8'h00);
    wait_idle();
    set_length(2);

    // Leading star, then a plain starred literal
    push_req(wsrm_pkg::OP_WRITE, 5'd0, wsrm_pkg::SYM_STAR);
    push_req(wsrm_pkg::OP_WRITE, 5'd1, 8'h61);
    push_req(wsrm_pkg::OP_START, 5'd0, 8'h00);
    push_req(wsrm_pkg::OP_BYTE, 5'd0, 8'h61);
    push_req(wsrm_pkg::OP_WRITE, 5'd0, 8'h61);
    push_req(wsrm_pkg::OP_WRITE, 5'd1, wsrm_pkg::SYM_STAR);
    push_req(wsrm_pkg::OP_START, 5'd0, 8'h00);
    push_req(wsrm_pkg::OP_BYTE, 5'd0, 8'h61);
    push_req(wsrm_pkg::OP_BYTE, 5'd0, 8'h61);
    push_req(wsrm_pkg::OP_BYTE, 5'd0, 8'h62);
    wait_idle();
    set_length(3);

    // Star after star, and a dot against the byte extremes
    push_req(wsrm_pkg::OP_WRITE, 5'd2, wsrm_pkg::SYM_STAR);
    push_req(wsrm_pkg::OP_START, 5'd0, 8'h00);
    push_req(wsrm_pkg::OP_BYTE, 5'd0, wsrm_pkg::SYM_STAR);
    push_req(wsrm_pkg::OP_BYTE, 5'd0, 8'h61);
    push_req(wsrm_pkg::OP_BYTE, 5'd0, wsrm_pkg::SYM_STAR);
    push_req(wsrm_pkg::OP_WRITE, 5'd0, wsrm_pkg::SYM_DOT);
    push_req(wsrm_pkg::OP_START, 5'd0, 8'h00);
    push_req(wsrm_pkg::OP_BYTE, 5'd0, 8'hFF);
    push_req(wsrm_pkg::OP_BYTE, 5'd0, 8'h00);
    wait_idle();

    // Random phases over lengths and idling modes
    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_length(phase_length(ph));
      idle_mode = idle_mode_e'(ph % 4);
      fill_random_phase(phase_length(ph), PHASE_REQ);
      if (ph == 2) begin
        @(posedge clk_i);
        hold_left <= HOLD_LEN;
      end
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
